// ----- rtl/core/cpc_pkg.sv -----
// shared widths, types and codes for the circle placement checker
package cpc_pkg;

    localparam int MAX_CIRCLES = 64;
    localparam int COORD_W     = 24;
    localparam int RAD_W       = COORD_W - 1;
    localparam int LABEL_W     = 17;
    localparam int TGT_W       = 7;
    localparam int IDX_W       = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);
    localparam int CMP_W       = (CNT_W > TGT_W) ? CNT_W : TGT_W;
    localparam int SQ_W        = 2 * COORD_W;

    // configuration register indexes
    localparam logic [1:0] REG_AREA_MIN = 2'd0;
    localparam logic [1:0] REG_AREA_MAX = 2'd1;
    localparam logic [1:0] REG_TARGET   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_ACCEPT  = 2'd0;
    localparam logic [1:0] STAT_BOUNDS  = 2'd1;
    localparam logic [1:0] STAT_OVERLAP = 2'd2;
    localparam logic [1:0] STAT_TARGET  = 2'd3;

    // label thresholds in units of 1/256
    localparam logic [LABEL_W-1:0] LABEL_T3 = LABEL_W'(300 * 256);
    localparam logic [LABEL_W-1:0] LABEL_T2 = LABEL_W'(200 * 256);
    localparam logic [LABEL_W-1:0] LABEL_T1 = LABEL_W'(100 * 256);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

endpackage

// ----- rtl/core/cpc_store.sv -----
// circle store: one write port, one registered read port
module cpc_store
    import cpc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [MAX_CIRCLES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/cpc_overlap_pipe.sv -----
// pipelined exact overlap test of one stored circle against the candidate
module cpc_overlap_pipe
    import cpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl_in,
    input  entry_t    entry,
    input  entry_t    cand,
    output pipe_ctl_t ctl_out,
    output logic      hit
);

    pipe_ctl_t ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg, rs_reg;
    logic [SQ_W-1:0]    dx2_reg, dy2_reg, rs2_reg;
    logic               hit_reg;

    logic signed [COORD_W:0] ddx, ddy;
    logic [COORD_W-1:0]      dx_next, dy_next, rs_next;
    logic [SQ_W:0]           dsum;

    always_comb
    begin
        ddx     = {entry.x[COORD_W-1], entry.x} - {cand.x[COORD_W-1], cand.x};
        ddy     = {entry.y[COORD_W-1], entry.y} - {cand.y[COORD_W-1], cand.y};
        dx_next = ddx[COORD_W] ? COORD_W'(-ddx) : COORD_W'(ddx);
        dy_next = ddy[COORD_W] ? COORD_W'(-ddy) : COORD_W'(ddy);
        rs_next = {1'b0, entry.r} + {1'b0, cand.r};
        dsum    = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    end

    // control travels alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        rs_reg  <= rs_next;
        dx2_reg <= {{COORD_W{1'b0}}, dx_reg} * {{COORD_W{1'b0}}, dx_reg};
        dy2_reg <= {{COORD_W{1'b0}}, dy_reg} * {{COORD_W{1'b0}}, dy_reg};
        rs2_reg <= {{COORD_W{1'b0}}, rs_reg} * {{COORD_W{1'b0}}, rs_reg};
        hit_reg <= dsum < {1'b0, rs2_reg};
    end

    assign ctl_out = ctl_c_reg;
    assign hit     = hit_reg;

endmodule

// ----- rtl/core/circle_placement_checker.sv -----
// top level: candidate checking sequencer, configuration and result register
//
// One candidate circle is taken at a time. The bound and target checks
// run in the check state; if the item passes, the stored circles are read from
// the store one per cycle and streamed through a four-stage overlap pipe
// (read, distance, squares, compare). The longest scan is over 63 circles,
// because a full store of 64 means the target is reached. An item rejected
// by the bounds or the target, or one that meets an empty store, skips the
// scan and goes straight to the final state. The result sits in an output
// register, so the next candidate is taken while a result waits; a finished
// item holds in its final cycle only if the previous result has not been
// taken yet.
// Configuration writes are accepted in every cycle (cfg_ready is tied high)
// and must only be made while no item is in progress.
module circle_placement_checker
    import cpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // candidate channel
    input  logic                      cand_valid,
    output logic                      cand_stall,
    input  logic signed [COORD_W-1:0] cand_x,
    input  logic signed [COORD_W-1:0] cand_y,
    input  logic [RAD_W-1:0]          cand_radius,
    input  logic [LABEL_W-1:0]        label_draw,
    // result channel
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [1:0]                status,
    output logic [1:0]                obstacle_type,
    output logic [5:0]                obstacle_number,
    output logic [6:0]                placed_count,
    output logic                      done_res,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [COORD_W-1:0] area_min_reg, area_max_reg;
    logic [TGT_W-1:0]          target_reg;

    // candidate held for the whole item
    entry_t             cand_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [1:0]         stat_reg;

    // placement state
    logic [CNT_W-1:0] stored_count_reg;
    logic [CNT_W-1:0] type_cnt_reg [4];

    // scan control
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issuing_reg;
    pipe_ctl_t        rd_ctl_reg;

    // result register
    logic             res_valid_reg;
    logic [1:0]       res_status_reg, res_type_reg;
    logic [5:0]       res_number_reg;
    logic [6:0]       res_count_reg;
    logic             res_done_reg;

    // datapath links
    entry_t    rdata;
    pipe_ctl_t hit_ctl;
    logic      hit;
    logic      rd_en, rd_last;
    logic      mem_we;

    logic                      cand_take, fin_go, accept_now;
    logic [CMP_W-1:0]          eff_target;
    logic                      at_target, after_done;
    logic signed [COORD_W+1:0] xp, xm, yp, ym, lo_e, hi_e, r_e;
    logic                      out_of_bounds;
    logic [1:0]                cand_type;
    logic [CNT_W-1:0]          count_after;

    assign cfg_ready  = 1'b1;
    assign cand_stall = (state_reg != ST_IDLE);
    assign cand_take  = cand_valid && !cand_stall;
    assign fin_go     = (state_reg == ST_FIN) && (!res_valid_reg || !res_stall);
    assign accept_now = fin_go && (stat_reg == STAT_ACCEPT);

    // effective target is capped by the store depth
    always_comb
    begin
        if (CMP_W'(target_reg) > CMP_W'(MAX_CIRCLES))
        begin
            eff_target = CMP_W'(MAX_CIRCLES);
        end
        else
        begin
            eff_target = CMP_W'(target_reg);
        end
        at_target = CMP_W'(stored_count_reg) >= eff_target;
    end

    // bound check, all edges of the circle inside the square
    always_comb
    begin
        r_e  = {3'b000, cand_reg.r};
        lo_e = {{2{area_min_reg[COORD_W-1]}}, area_min_reg};
        hi_e = {{2{area_max_reg[COORD_W-1]}}, area_max_reg};
        xp   = {{2{cand_reg.x[COORD_W-1]}}, cand_reg.x} + r_e;
        xm   = {{2{cand_reg.x[COORD_W-1]}}, cand_reg.x} - r_e;
        yp   = {{2{cand_reg.y[COORD_W-1]}}, cand_reg.y} + r_e;
        ym   = {{2{cand_reg.y[COORD_W-1]}}, cand_reg.y} - r_e;
        out_of_bounds = (xp > hi_e) || (xm < lo_e) || (yp > hi_e) || (ym < lo_e);
    end

    // type from label, strictly above each threshold
    always_comb
    begin
        if (label_reg > LABEL_T3)
        begin
            cand_type = 2'd3;
        end
        else if (label_reg > LABEL_T2)
        begin
            cand_type = 2'd2;
        end
        else if (label_reg > LABEL_T1)
        begin
            cand_type = 2'd1;
        end
        else
        begin
            cand_type = 2'd0;
        end
        count_after = accept_now ? stored_count_reg + CNT_W'(1) : stored_count_reg;
        after_done  = CMP_W'(count_after) >= eff_target;
    end

    assign rd_en   = (state_reg == ST_SCAN) && issuing_reg;
    assign rd_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == stored_count_reg;
    assign mem_we  = accept_now;

    // configuration decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_min_reg <= -COORD_W'(40960);
            area_max_reg <= COORD_W'(40960);
            target_reg   <= TGT_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AREA_MIN: area_min_reg <= cfg_data;
                REG_AREA_MAX: area_max_reg <= cfg_data;
                REG_TARGET:   target_reg   <= cfg_data[TGT_W-1:0];
                default:      ;
            endcase
        end
    end

    // candidate capture
    always_ff @(posedge clk)
    begin
        if (cand_take)
        begin
            cand_reg.x <= cand_x;
            cand_reg.y <= cand_y;
            cand_reg.r <= cand_radius;
            label_reg  <= label_draw;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stat_reg         <= STAT_ACCEPT;
            stored_count_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                type_cnt_reg[i] <= '0;
            end
            rd_idx_reg       <= '0;
            issuing_reg      <= 1'b0;
            rd_ctl_reg       <= '0;
        end
        else
        begin
            rd_ctl_reg.valid <= rd_en;
            rd_ctl_reg.last  <= rd_last;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cand_take)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    rd_idx_reg <= '0;
                    if (at_target)
                    begin
                        stat_reg  <= STAT_TARGET;
                        state_reg <= ST_FIN;
                    end
                    else if (out_of_bounds)
                    begin
                        stat_reg  <= STAT_BOUNDS;
                        state_reg <= ST_FIN;
                    end
                    else if (stored_count_reg == '0)
                    begin
                        stat_reg  <= STAT_ACCEPT;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        stat_reg    <= STAT_ACCEPT;
                        issuing_reg <= 1'b1;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issuing_reg)
                    begin
                        if (rd_last)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                        end
                    end
                    // overlap is sticky, the rest of the scan just drains
                    if (hit_ctl.valid && hit)
                    begin
                        stat_reg <= STAT_OVERLAP;
                    end
                    if (hit_ctl.valid && hit_ctl.last)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        if (accept_now)
                        begin
                            stored_count_reg        <= count_after;
                            type_cnt_reg[cand_type] <= type_cnt_reg[cand_type] + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            res_status_reg <= stat_reg;
            res_type_reg   <= accept_now ? cand_type : 2'd0;
            res_number_reg <= accept_now ? 6'(type_cnt_reg[cand_type]) : 6'd0;
            res_count_reg  <= 7'(CMP_W'(count_after));
            res_done_reg   <= after_done;
        end
    end

    assign res_valid       = res_valid_reg;
    assign status          = res_status_reg;
    assign obstacle_type   = res_type_reg;
    assign obstacle_number = res_number_reg;
    assign placed_count    = res_count_reg;
    assign done_res        = res_done_reg;

    cpc_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (stored_count_reg[IDX_W-1:0]),
        .wdata (cand_reg),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    cpc_overlap_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (rd_ctl_reg),
        .entry   (rdata),
        .cand    (cand_reg),
        .ctl_out (hit_ctl),
        .hit     (hit)
    );

    // store never runs past its depth
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_W'(MAX_CIRCLES))
        else $error("stored count above store depth");

    // per-type counts always add up to the stored count
    a_type_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({2'b00, type_cnt_reg[0]} + {2'b00, type_cnt_reg[1]} + {2'b00, type_cnt_reg[2]}
         + {2'b00, type_cnt_reg[3]}) == {2'b00, stored_count_reg})
        else $error("type counts disagree with stored count");

    // overlap results only come back while scanning
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        hit_ctl.valid |-> (state_reg == ST_SCAN))
        else $error("overlap result outside of scan");

    // an accepted item grows the store by exactly one
    a_accept_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept_now |=> stored_count_reg == $past(stored_count_reg) + CNT_W'(1))
        else $error("accepted item did not grow the store");

    // rejected items carry no type and no number
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status != STAT_ACCEPT)) |->
        ((obstacle_type == 2'd0) && (obstacle_number == 6'd0)))
        else $error("rejected item with type or number");

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the circle placement checker
module testbench
    import cpc_pkg::*;
();

    // ------------------------------------------------------------------
    // types
    // ------------------------------------------------------------------

    // one result item as the block reports it
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [5:0] number;
        logic [6:0] count;
        logic       done;
    } outcome_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
        logic [LABEL_W-1:0]        label;
        logic                      typed;
        outcome_t                  want;
    } probe_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // one phase of the random part: area, target, idling and length
    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic [TGT_W-1:0]          tgt;
        idle_mode_t                mode;
        int                        items;
        int                        hold_at;
    } phase_t;

    localparam outcome_t PREDICTED = '0;

    // directed items, run with the reset settings (area -10.0 .. +10.0,
    // target 16); positions in Q11.12, so 4096 is one unit
    localparam int NUM_PROBES = 16;
    localparam probe_t PROBES [NUM_PROBES] = '{
        // first circle into an empty store
        '{24'sd0, 24'sd0, 23'd4096, 17'd0, 1'b1,
          '{STAT_ACCEPT, 2'd0, 6'd0, 7'd1, 1'b0}},
        // most negative x, most positive y, largest radius, top label
        '{-24'sd8388608, 24'sd8388607, 23'd8388607, 17'd102400, 1'b1,
          '{STAT_BOUNDS, 2'd0, 6'd0, 7'd1, 1'b0}},
        '{24'sd8388607, 24'sd0, 23'd0, 17'd0, 1'b1,
          '{STAT_BOUNDS, 2'd0, 6'd0, 7'd1, 1'b0}},
        // touches the right bound, label just above the first threshold
        '{24'sd36864, 24'sd0, 23'd4096, 17'd25601, 1'b0, PREDICTED},
        // touches the first circle exactly
        '{24'sd0, 24'sd8192, 23'd4096, 17'd51201, 1'b0, PREDICTED},
        // point on the first circle's centre
        '{24'sd0, 24'sd0, 23'd0, 17'd0, 1'b1,
          '{STAT_OVERLAP, 2'd0, 6'd0, 7'd3, 1'b0}},
        // labels on each threshold and just above the top one
        '{-24'sd20480, -24'sd20480, 23'd4096, 17'd76801, 1'b0, PREDICTED},
        '{-24'sd20480, 24'sd20480, 23'd4096, 17'd76800, 1'b0, PREDICTED},
        '{24'sd20480, -24'sd20480, 23'd2048, 17'd51200, 1'b0, PREDICTED},
        '{24'sd20480, 24'sd20480, 23'd2048, 17'd25600, 1'b0, PREDICTED},
        // touches the left bound
        '{-24'sd36864, 24'sd0, 23'd4096, 17'd102400, 1'b0, PREDICTED},
        // one lsb past the top bound
        '{24'sd0, 24'sd40961, 23'd0, 17'd0, 1'b1,
          '{STAT_BOUNDS, 2'd0, 6'd0, 7'd8, 1'b0}},
        '{24'sd0, 24'sd0, 23'd8388607, 17'd102400, 1'b1,
          '{STAT_BOUNDS, 2'd0, 6'd0, 7'd8, 1'b0}},
        // zero radius on the lower corner
        '{-24'sd40960, -24'sd40960, 23'd0, 17'd0, 1'b0, PREDICTED},
        '{24'sd40960, 24'sd40960, 23'd1, 17'd0, 1'b1,
          '{STAT_BOUNDS, 2'd0, 6'd0, 7'd9, 1'b0}},
        // one lsb short of touching the first circle
        '{24'sd0, -24'sd8191, 23'd4096, 17'd0, 1'b1,
          '{STAT_OVERLAP, 2'd0, 6'd0, 7'd9, 1'b0}}
    };

    // random phases; the target rises in small steps so that most items
    // see a partly filled store and scan it, with the odd settings between
    localparam int NUM_PHASES = 13;
    localparam phase_t PHASES [NUM_PHASES] = '{
        '{-24'sd40960, 24'sd40960, 7'd20, IDLE_NONE, 150, 40},
        '{-24'sd40960, 24'sd40960, 7'd24, IDLE_SEND, 120, -1},
        '{-24'sd40960, 24'sd40960, 7'd28, IDLE_RECV, 120, -1},
        '{-24'sd40960, 24'sd40960, 7'd32, IDLE_BOTH, 120, -1},
        // inverted area: nothing fits
        '{24'sd8388607, -24'sd8388608, 7'd127, IDLE_NONE, 50, -1},
        // target zero, then lowered below the stored count
        '{-24'sd8388608, 24'sd8388607, 7'd0, IDLE_SEND, 40, -1},
        '{-24'sd8388608, 24'sd8388607, 7'd1, IDLE_RECV, 40, -1},
        // widest area
        '{-24'sd8388608, 24'sd8388607, 7'd40, IDLE_BOTH, 150, -1},
        '{-24'sd400000, 24'sd400000, 7'd48, IDLE_NONE, 150, 60},
        '{-24'sd400000, 24'sd400000, 7'd56, IDLE_SEND, 150, -1},
        '{-24'sd4096, 24'sd4096, 7'd60, IDLE_RECV, 150, -1},
        // targets above the store size
        '{-24'sd8388608, 24'sd8388607, 7'd100, IDLE_BOTH, 150, -1},
        '{-24'sd40960, 24'sd40960, 7'd127, IDLE_NONE, 150, -1}
    };

    localparam int HOLD_CYCLES = 400;
    localparam int MAX_GAP     = 20;
    localparam int TAIL_CYCLES = 80;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n           = 1'b0;
    logic                      cand_valid      = 1'b0;
    logic                      cand_stall;
    logic signed [COORD_W-1:0] cand_x          = '0;
    logic signed [COORD_W-1:0] cand_y          = '0;
    logic [RAD_W-1:0]          cand_radius     = '0;
    logic [LABEL_W-1:0]        label_draw      = '0;
    logic                      res_valid;
    logic                      res_stall       = 1'b0;
    logic [1:0]                status;
    logic [1:0]                obstacle_type;
    logic [5:0]                obstacle_number;
    logic [6:0]                placed_count;
    logic                      done_res;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index       = '0;
    logic [COORD_W-1:0]        cfg_data        = '0;

    circle_placement_checker u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cand_valid      (cand_valid),
        .cand_stall      (cand_stall),
        .cand_x          (cand_x),
        .cand_y          (cand_y),
        .cand_radius     (cand_radius),
        .label_draw      (label_draw),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .obstacle_type   (obstacle_type),
        .obstacle_number (obstacle_number),
        .placed_count    (placed_count),
        .done_res        (done_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // shadow of the block: stored circles, per-type tallies, settings
    // ------------------------------------------------------------------
    longint   placed_x [MAX_CIRCLES];
    longint   placed_y [MAX_CIRCLES];
    longint   placed_r [MAX_CIRCLES];
    int       type_tally [4];
    int       n_placed;
    longint   bound_lo;
    longint   bound_hi;
    int       goal;

    outcome_t pending_outcomes [$];
    int       mismatch_count   = 0;
    int       status_seen [4]  = '{default: 0};
    int       items_sent;

    // idling controls; percentages of cycles
    int       tx_pct;
    int       rx_pct;
    logic     hold_kick = 1'b0;
    logic     hold_seen = 1'b0;
    int       hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // works out what one accepted candidate produces and updates the shadow
    function automatic outcome_t place_candidate(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [RAD_W-1:0]          r,
        input logic [LABEL_W-1:0]        label
    );
        outcome_t o;
        int       limit;
        int       i;
        int       t;
        longint   cx;
        longint   cy;
        longint   cr;
        longint   dx;
        longint   dy;
        longint   rs;
        logic     hit;
        o     = '0;
        hit   = 1'b0;
        cx    = longint'(x);
        cy    = longint'(y);
        cr    = longint'(r);
        // a target above the store size is capped at the store size
        limit = (goal < MAX_CIRCLES) ? goal : MAX_CIRCLES;
        if (n_placed >= limit)
        begin
            o.status = STAT_TARGET;
        end
        else if (cx + cr > bound_hi || cx - cr < bound_lo ||
                 cy + cr > bound_hi || cy - cr < bound_lo)
        begin
            o.status = STAT_BOUNDS;
        end
        else
        begin
            // exact squared test; touching at the radius sum is no overlap
            for (i = 0; i < n_placed && !hit; i++)
            begin
                dx = placed_x[i] - cx;
                dy = placed_y[i] - cy;
                rs = placed_r[i] + cr;
                if (dx * dx + dy * dy < rs * rs)
                    hit = 1'b1;
            end
            if (hit)
            begin
                o.status = STAT_OVERLAP;
            end
            else
            begin
                if (label > LABEL_T3)
                    t = 3;
                else if (label > LABEL_T2)
                    t = 2;
                else if (label > LABEL_T1)
                    t = 1;
                else
                    t = 0;
                o.status = STAT_ACCEPT;
                o.kind   = 2'(t);
                o.number = 6'(type_tally[t]);
                type_tally[t]++;
                placed_x[n_placed] = cx;
                placed_y[n_placed] = cy;
                placed_r[n_placed] = cr;
                n_placed++;
            end
        end
        o.count = 7'(n_placed);
        o.done  = (n_placed >= limit);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, with a long hold-off when kicked
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // compare each taken result with the oldest outstanding one
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, status", status, -1);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                status_seen[want.status]++;
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (obstacle_type !== want.kind)
                    report_mismatch("obstacle_type", obstacle_type, want.kind);
                if (obstacle_number !== want.number)
                    report_mismatch("obstacle_number", obstacle_number, want.number);
                if (placed_count !== want.count)
                    report_mismatch("placed_count", placed_count, want.count);
                if (done_res !== want.done)
                    report_mismatch("done_res", done_res, want.done);
            end
        end
    end

    // ------------------------------------------------------------------
    // candidate side
    // ------------------------------------------------------------------

    // offers one item after a random gap, waits for it to be taken and
    // queues its result; valid stays high afterward for the caller to decide
    task automatic offer_candidate(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [RAD_W-1:0]          r,
        input logic [LABEL_W-1:0]        label,
        input logic                      typed,
        input outcome_t                  want
    );
        int       gap;
        outcome_t got;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_pct)
            gap++;
        if (gap > 0)
        begin
            cand_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_valid  <= 1'b1;
        cand_x      <= x;
        cand_y      <= y;
        cand_radius <= r;
        label_draw  <= label;
        @(posedge clk);
        while (cand_stall)
            @(posedge clk);
        got = place_candidate(x, y, r, label);
        pending_outcomes.insert(pending_outcomes.size(), typed ? want : got);
        items_sent++;
    endtask

    // random candidate: mostly inside the area, many placed right against
    // a stored circle (touching or one lsb into it), some anywhere at all
    task automatic make_candidate(
        output logic signed [COORD_W-1:0] x,
        output logic signed [COORD_W-1:0] y,
        output logic [RAD_W-1:0]          r,
        output logic [LABEL_W-1:0]        label
    );
        int     pick;
        int     i;
        longint span;
        longint reach;
        longint cx;
        longint cy;
        pick = $urandom_range(99);
        if (pick < 15 || bound_lo > bound_hi)
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            r = RAD_W'($urandom);
        end
        else if (pick < 55 && n_placed > 0)
        begin
            i     = $urandom_range(n_placed - 1);
            r     = RAD_W'($urandom_range(8192));
            reach = placed_r[i] + longint'(r) - longint'($urandom_range(1));
            cx    = placed_x[i];
            cy    = placed_y[i];
            case ($urandom_range(3))
                0:       cx = cx + reach;
                1:       cx = cx - reach;
                2:       cy = cy + reach;
                default: cy = cy - reach;
            endcase
            x = cx[COORD_W-1:0];
            y = cy[COORD_W-1:0];
        end
        else
        begin
            span = bound_hi - bound_lo;
            cx   = bound_lo + longint'($urandom_range(32'(span)));
            cy   = bound_lo + longint'($urandom_range(32'(span)));
            x    = cx[COORD_W-1:0];
            y    = cy[COORD_W-1:0];
            r    = RAD_W'($urandom_range(32'(span / 8)));
        end
        // labels on the thresholds now and then
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(7))
                0:       label = LABEL_T1;
                1:       label = LABEL_T1 + 1'b1;
                2:       label = LABEL_T2;
                3:       label = LABEL_T2 + 1'b1;
                4:       label = LABEL_T3;
                5:       label = LABEL_T3 + 1'b1;
                6:       label = '0;
                default: label = LABEL_W'(102400);
            endcase
        end
        else
        begin
            label = LABEL_W'($urandom_range(102400));
        end
    endtask

    // holds off until every queued result has come back
    task automatic wait_drained();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // one register write; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_AREA_MIN: bound_lo = longint'($signed(val));
            REG_AREA_MAX: bound_hi = longint'($signed(val));
            REG_TARGET:   goal     = int'(val[TGT_W-1:0]);
            default:      ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int                        p;
        int                        k;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
        logic [LABEL_W-1:0]        label;

        // reset values of the shadow
        n_placed       = 0;
        type_tally     = '{default: 0};
        bound_lo       = -40960;
        bound_hi       = 40960;
        goal           = 16;
        items_sent     = 0;
        tx_pct         = 0;
        rx_pct         = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table with the reset settings, no idling
        for (k = 0; k < NUM_PROBES; k++)
            offer_candidate(PROBES[k].x, PROBES[k].y, PROBES[k].r, PROBES[k].label,
                            PROBES[k].typed, PROBES[k].want);
        cand_valid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // settings only change with the block empty
            wait_drained();
            write_reg(REG_AREA_MIN, PHASES[p].lo);
            write_reg(REG_AREA_MAX, PHASES[p].hi);
            write_reg(REG_TARGET, COORD_W'(PHASES[p].tgt));
            cfg_valid <= 1'b0;

            case (PHASES[p].mode)
                IDLE_SEND: begin tx_pct = 52; rx_pct = 0;  end
                IDLE_RECV: begin tx_pct = 0;  rx_pct = 52; end
                IDLE_BOTH: begin tx_pct = 25; rx_pct = 25; end
                default:   begin tx_pct = 0;  rx_pct = 0;  end
            endcase

            for (k = 0; k < PHASES[p].items; k++)
            begin
                // long receiver hold-off while items keep coming
                if (k == PHASES[p].hold_at)
                    hold_kick <= ~hold_kick;
                make_candidate(x, y, r, label);
                offer_candidate(x, y, r, label, 1'b0, PREDICTED);
            end
            cand_valid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d candidates over %0d settings, %0d circles stored at the end",
                 items_sent, NUM_PHASES + 1, n_placed);
        $display("results: %0d placed, %0d out of area, %0d overlapping, %0d past target",
                 status_seen[STAT_ACCEPT], status_seen[STAT_BOUNDS],
                 status_seen[STAT_OVERLAP], status_seen[STAT_TARGET]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #8000000;
        $display("timeout with %0d results outstanding", pending_outcomes.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cpc_pkg.sv
rtl/core/cpc_store.sv
rtl/core/cpc_overlap_pipe.sv
rtl/core/circle_placement_checker.sv
verif/testbench.sv
